// ===== design/srr_pkg.sv =====
// Package: shared constants and word types of the selective-repeat reorder receiver.
package srr_pkg;

  // Receive window storage and sequence number space
  localparam int unsigned WINDOW_SLOTS = 32;
  localparam int unsigned SLOT_BITS    = $clog2(WINDOW_SLOTS);
  localparam int unsigned WIN_BITS     = $clog2(WINDOW_SLOTS + 1);
  localparam int unsigned SEQ_BITS     = 16;

  // Field widths of the words
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned TIME_W = 63;
  localparam int unsigned LIM_W  = 6;

  // Reset values
  localparam logic [SEQ_BITS-1:0] EXPECTED_RST = SEQ_BITS'(1);
  localparam logic [LIM_W-1:0]    LIMIT_RST    = LIM_W'(20);

  // Result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // Input word
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] arrival_time;
    logic              drop;
  } srr_in_t;

  // Result word
  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [TIME_W-1:0] out_time;
    logic              beyond_window;
    logic              last;
  } srr_out_t;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ACK   = 4'b0010,
    S_READ  = 4'b0100,
    S_DELIV = 4'b1000
  } srr_state_e;

endpackage

// ===== design/srr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module srr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/selective_repeat_reorder_receiver.sv =====
// Top level: selective-repeat receiver that acknowledges and reorders packets.
//
// Usage:
//   Input channel: a word on in_i is taken at a clock edge with start high and
//   busy low. A word with drop set is discarded and leaves busy low.
//   Result channel: each result word sits on res_o for exactly one cycle,
//   marked by res_valid_o; the receiver takes it in that cycle.
//   Every kept word first yields an acknowledgement, then one delivery word
//   per slot in the in-order run starting at the expected sequence number.
//   last marks the final result of a word.
//   Configuration: cfg_we_i writes the window limit from cfg_wdata_i; write
//   only while busy is low.
// Order of events:
//   After the accept edge the acknowledgement passes through S_ACK and
//   the result register. For a word with no delivery, busy falls as its
//   acknowledgement shows, so the next word can be accepted while it shows.
//   A delivery run first issues the read of the time RAM in S_READ, then
//   delivers the packets in S_DELIV as each read overlaps the previous output.
// Reset: expected sequence number 1, window base slot 0, all slots empty,
//   window limit 20. Stored times are not cleared; no sweep is needed.
module selective_repeat_reorder_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  srr_pkg::srr_in_t               in_i,
  input  logic                           cfg_we_i,
  input  logic [srr_pkg::LIM_W-1:0]      cfg_wdata_i,
  output logic                           res_valid_o,
  output srr_pkg::srr_out_t              res_o
);

  srr_pkg::srr_state_e                  state_q, state_d;
  logic [srr_pkg::SEQ_BITS-1:0]         expected_q, expected_d;
  logic [srr_pkg::SLOT_BITS-1:0]        base_q, base_d;
  logic [srr_pkg::WINDOW_SLOTS-1:0]     valid_q, valid_d;
  logic [srr_pkg::LIM_W-1:0]            limit_q, limit_d;
  logic                                 res_valid_q, res_valid_d;
  srr_pkg::srr_out_t                    res_q, res_d;
  srr_pkg::srr_in_t                     in_q;

  logic                                 accept;
  logic [srr_pkg::SEQ_BITS-1:0]         seq_gap;
  logic [srr_pkg::WIN_BITS-1:0]         win;
  logic                                 in_win;
  logic [srr_pkg::SLOT_BITS-1:0]        wr_idx;
  logic                                 do_write;
  logic [srr_pkg::WINDOW_SLOTS-1:0]     valid_ack;
  logic [srr_pkg::SLOT_BITS-1:0]        base_nx;
  logic                                 ram_re;
  logic [srr_pkg::SLOT_BITS-1:0]        ram_raddr;
  logic [srr_pkg::TIME_W-1:0]           ram_rdata;

  assign busy   = (state_q != srr_pkg::S_IDLE);
  assign accept = start && !busy && !in_i.drop;

  // Window placement of the held word
  always_comb begin
    seq_gap = srr_pkg::SEQ_BITS'(in_q.seq) - expected_q;
    win     = (32'(limit_q) > srr_pkg::WINDOW_SLOTS) ?
              srr_pkg::WIN_BITS'(srr_pkg::WINDOW_SLOTS) : srr_pkg::WIN_BITS'(limit_q);
    in_win  = 32'(seq_gap) < 32'(win);
    wr_idx  = base_q + srr_pkg::SLOT_BITS'(seq_gap);
    do_write = in_win && !valid_q[wr_idx];
    valid_ack = valid_q;
    if (do_write) begin
      valid_ack[wr_idx] = 1'b1;
    end
  end

  assign base_nx = base_q + srr_pkg::SLOT_BITS'(1);

  // Controller
  always_comb begin
    state_d     = state_q;
    expected_d  = expected_q;
    base_d      = base_q;
    valid_d     = valid_q;
    limit_d     = limit_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_re      = 1'b0;
    ram_raddr   = base_q;

    if (cfg_we_i) begin
      limit_d = cfg_wdata_i;
    end

    unique case (state_q)
      srr_pkg::S_IDLE: begin
        if (accept) begin
          state_d = srr_pkg::S_ACK;
        end
      end
      srr_pkg::S_ACK: begin
        valid_d             = valid_ack;
        res_valid_d         = 1'b1;
        res_d.kind          = srr_pkg::KIND_ACK;
        res_d.out_seq       = in_q.seq;
        res_d.out_time      = '0;
        res_d.beyond_window = !in_win && !seq_gap[srr_pkg::SEQ_BITS-1];
        res_d.last          = !valid_ack[base_q];
        state_d = valid_ack[base_q] ? srr_pkg::S_READ : srr_pkg::S_IDLE;
      end
      srr_pkg::S_READ: begin
        // fetch the time of the head slot
        ram_re    = 1'b1;
        ram_raddr = base_q;
        state_d   = srr_pkg::S_DELIV;
      end
      srr_pkg::S_DELIV: begin
        // deliver head slot, prefetch the next one
        res_valid_d         = 1'b1;
        res_d.kind          = srr_pkg::KIND_DELIVER;
        res_d.out_seq       = srr_pkg::SEQ_W'(expected_q);
        res_d.out_time      = ram_rdata;
        res_d.beyond_window = 1'b0;
        res_d.last          = !valid_q[base_nx];
        valid_d[base_q]     = 1'b0;
        expected_d          = expected_q + srr_pkg::SEQ_BITS'(1);
        base_d              = base_nx;
        ram_re              = valid_q[base_nx];
        ram_raddr           = base_nx;
        state_d = valid_q[base_nx] ? srr_pkg::S_DELIV : srr_pkg::S_IDLE;
      end
      default: begin
        state_d = srr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srr_pkg::S_IDLE;
      expected_q  <= srr_pkg::EXPECTED_RST;
      base_q      <= '0;
      valid_q     <= '0;
      limit_q     <= srr_pkg::LIMIT_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      expected_q  <= expected_d;
      base_q      <= base_d;
      valid_q     <= valid_d;
      limit_q     <= limit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    res_q <= res_d;
  end

  // Arrival time store, written once per newly filled slot
  srr_ram #(
    .WIDTH (srr_pkg::TIME_W),
    .DEPTH (srr_pkg::WINDOW_SLOTS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == srr_pkg::S_ACK) && do_write),
    .waddr_i (wr_idx),
    .wdata_i (in_q.arrival_time),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/srr_checker.sv =====
// Checker: port-level assertions for the selective-repeat reorder receiver.
module srr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input srr_pkg::srr_in_t          in_i,
  input logic                      res_valid_o,
  input srr_pkg::srr_out_t         res_o
);

  // A kept word makes the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !in_i.drop |=> busy)
    else $error("busy not raised after accepted word");

  // A dropped word leaves the block free
  a_drop_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.drop |=> !busy)
    else $error("dropped word started work");

  // The acknowledgement follows accept, through S_ACK and the result register, and echoes seq
  a_ack_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !in_i.drop |=> ##1 (res_valid_o &&
      res_o.kind == srr_pkg::KIND_ACK && res_o.out_seq == $past(in_i.seq, 2)))
    else $error("acknowledgement missing or wrong");

  // More results pending keeps the block busy
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("free while results remain");

  // Acknowledgements carry no time
  a_ack_time_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == srr_pkg::KIND_ACK |-> res_o.out_time == '0)
    else $error("acknowledgement carries a time");

endmodule

bind selective_repeat_reorder_receiver srr_checker u_srr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .in_i        (in_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
